>>> hw/rtl/pcx_rle_decoder_assert.svh
// ----------------------------------------------------------------------------
// PCX RLE decoder assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_DECODER_ASSERT_SVH
`define PCX_RLE_DECODER_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define PCX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcx_rle_decoder assertion failed");

// Checks the consequent in the cycle after the antecedent.
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcx_rle_decoder assertion failed");

`endif

>>> hw/rtl/pcx_rle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Types and constants shared by the decoder's front end, queue and back end.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

    localparam logic [7:0] HDR_LEN_M1  = 8'd127;
    localparam logic [7:0] PCX_MAKER   = 8'd10;
    localparam logic [7:0] PIX_BITS    = 8'd8;
    localparam logic [7:0] ONE_PLANE   = 8'd1;
    localparam logic [1:0] RUN_MARK    = 2'b11;

    localparam logic [7:0] OFS_MAKER   = 8'd0;
    localparam logic [7:0] OFS_ENCODE  = 8'd2;
    localparam logic [7:0] OFS_BPP     = 8'd3;
    localparam logic [7:0] OFS_XMIN_LO = 8'd4;
    localparam logic [7:0] OFS_XMIN_HI = 8'd5;
    localparam logic [7:0] OFS_YMIN_LO = 8'd6;
    localparam logic [7:0] OFS_YMIN_HI = 8'd7;
    localparam logic [7:0] OFS_XMAX_LO = 8'd8;
    localparam logic [7:0] OFS_XMAX_HI = 8'd9;
    localparam logic [7:0] OFS_YMAX_LO = 8'd10;
    localparam logic [7:0] OFS_YMAX_HI = 8'd11;
    localparam logic [7:0] OFS_PLANES  = 8'd65;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_SHORT      = 2'd2;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] pixel;
        logic [5:0] count;
        logic       stat_en;
        logic [1:0] status;
    } t_cmd;

endpackage

>>> hw/rtl/pcx_rle_front.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder front end
// Parses the header, tracks the pixel budget and turns each byte that
// yields pixels, and the last byte, into a command for the back end.
// ----------------------------------------------------------------------------
module pcx_rle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_file_byte,
    input  logic                i_last_byte,
    input  logic                i_q_full,
    output logic                o_q_push,
    output pcx_rle_pkg::t_cmd   o_q_cmd
);

    logic [7:0]  r_pos,  n_pos;
    logic        r_good, n_good;
    logic [15:0] r_xl, n_xl, r_yl, n_yl, r_xh, n_xh, r_yh, n_yh;
    logic [31:0] r_w, r_h, r_area;
    logic [31:0] r_left, n_left;
    logic        r_pend, n_pend;
    logic [5:0]  r_len,  n_len;

    logic        accept;
    logic [5:0]  cnt;
    logic [5:0]  run_cnt;
    logic [1:0]  st;

    assign accept = i_valid && !i_q_full;

    always_comb begin
        if ((r_left[31:6] == 26'd0) && (r_left[5:0] < r_len)) begin
            run_cnt = r_left[5:0];
        end else begin
            run_cnt = r_len;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_good = r_good;
        n_xl   = r_xl;
        n_yl   = r_yl;
        n_xh   = r_xh;
        n_yh   = r_yh;
        n_left = r_left;
        n_pend = r_pend;
        n_len  = r_len;
        cnt    = 6'd0;
        st     = pcx_rle_pkg::ST_OK;
        if (!r_pos[7]) begin
            n_pos = r_pos + 8'd1;
            unique case (r_pos)
                pcx_rle_pkg::OFS_MAKER: begin
                    if (i_file_byte != pcx_rle_pkg::PCX_MAKER) n_good = 1'b0;
                end
                pcx_rle_pkg::OFS_ENCODE: begin
                    if (i_file_byte == 8'd0) n_good = 1'b0;
                end
                pcx_rle_pkg::OFS_BPP: begin
                    if (i_file_byte != pcx_rle_pkg::PIX_BITS) n_good = 1'b0;
                end
                pcx_rle_pkg::OFS_XMIN_LO: n_xl[7:0]  = i_file_byte;
                pcx_rle_pkg::OFS_XMIN_HI: n_xl[15:8] = i_file_byte;
                pcx_rle_pkg::OFS_YMIN_LO: n_yl[7:0]  = i_file_byte;
                pcx_rle_pkg::OFS_YMIN_HI: n_yl[15:8] = i_file_byte;
                pcx_rle_pkg::OFS_XMAX_LO: n_xh[7:0]  = i_file_byte;
                pcx_rle_pkg::OFS_XMAX_HI: n_xh[15:8] = i_file_byte;
                pcx_rle_pkg::OFS_YMAX_LO: n_yh[7:0]  = i_file_byte;
                pcx_rle_pkg::OFS_YMAX_HI: n_yh[15:8] = i_file_byte;
                pcx_rle_pkg::OFS_PLANES: begin
                    if (i_file_byte != pcx_rle_pkg::ONE_PLANE) n_good = 1'b0;
                end
                pcx_rle_pkg::HDR_LEN_M1: begin
                    n_good = r_good && !(r_xh < r_xl);
                    n_left = (r_good && !(r_xh < r_xl)) ? r_area : 32'd0;
                end
                default: begin
                end
            endcase
        end else if (r_good && (r_left != 32'd0)) begin
            if (r_pend) begin
                cnt    = run_cnt;
                n_left = r_left - {26'd0, run_cnt};
                n_pend = 1'b0;
                n_len  = 6'd0;
            end else if (i_file_byte[7:6] == pcx_rle_pkg::RUN_MARK) begin
                n_pend = 1'b1;
                n_len  = i_file_byte[5:0];
            end else begin
                cnt    = 6'd1;
                n_left = r_left - 32'd1;
            end
        end
        if (n_pos != 8'd128 || !n_good) begin
            st = pcx_rle_pkg::ST_BAD_HEADER;
        end else if (n_left != 32'd0) begin
            st = pcx_rle_pkg::ST_SHORT;
        end
        if (i_last_byte) begin
            n_pos  = 8'd0;
            n_good = 1'b1;
            n_xl   = 16'd0;
            n_yl   = 16'd0;
            n_xh   = 16'd0;
            n_yh   = 16'd0;
            n_left = 32'd0;
            n_pend = 1'b0;
            n_len  = 6'd0;
        end
    end

    assign o_q_push        = accept && ((cnt != 6'd0) || i_last_byte);
    assign o_q_cmd.pixel   = i_file_byte;
    assign o_q_cmd.count   = cnt;
    assign o_q_cmd.stat_en = i_last_byte;
    assign o_q_cmd.status  = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 8'd0;
            r_good <= 1'b1;
            r_xl   <= 16'd0;
            r_yl   <= 16'd0;
            r_xh   <= 16'd0;
            r_yh   <= 16'd0;
            r_left <= 32'd0;
            r_pend <= 1'b0;
            r_len  <= 6'd0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_good <= n_good;
            r_xl   <= n_xl;
            r_yl   <= n_yl;
            r_xh   <= n_xh;
            r_yh   <= n_yh;
            r_left <= n_left;
            r_pend <= n_pend;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= {16'd0, r_xh} + 32'd1 - {16'd0, r_xl};
        r_h    <= {16'd0, r_yh} + 32'd1 - {16'd0, r_yl};
        r_area <= r_w * r_h;
    end

endmodule

>>> hw/rtl/pcx_rle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pcx_rle_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcx_rle_pkg::t_cmd   i_wdata,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output pcx_rle_pkg::t_cmd   o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcx_rle_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [CW-1:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/pcx_rle_back.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder back end
// Expands queued commands into pixel beats and a closing status beat.
// ----------------------------------------------------------------------------
module pcx_rle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  pcx_rle_pkg::t_cmd   i_q_cmd,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_kind,
    output logic [7:0]          o_pixel,
    output logic [1:0]          o_status,
    output logic                o_last
);

    logic [5:0] r_sent;
    logic       r_ovalid;
    logic       r_kind;
    logic [7:0] r_pixel;
    logic [1:0] r_status;
    logic       r_last;

    logic       advance;
    logic [5:0] remaining;
    logic       is_pixel;
    logic       finish;

    assign advance   = !r_ovalid || i_pop;
    assign remaining = i_q_cmd.count - r_sent;
    assign is_pixel  = (remaining != 6'd0);
    assign finish    = !is_pixel || ((remaining == 6'd1) && !i_q_cmd.stat_en);
    assign o_q_pop   = advance && !i_q_empty && finish;

    assign o_empty  = !r_ovalid;
    assign o_kind   = r_kind;
    assign o_pixel  = r_pixel;
    assign o_status = r_status;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent   <= 6'd0;
            r_ovalid <= 1'b0;
        end else if (advance) begin
            r_ovalid <= !i_q_empty;
            if (!i_q_empty) begin
                r_sent <= finish ? 6'd0 : r_sent + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_q_empty) begin
            r_last <= finish;
            if (is_pixel) begin
                r_kind   <= pcx_rle_pkg::KIND_PIXEL;
                r_pixel  <= i_q_cmd.pixel;
                r_status <= pcx_rle_pkg::ST_OK;
            end else begin
                r_kind   <= pcx_rle_pkg::KIND_STATUS;
                r_pixel  <= 8'd0;
                r_status <= i_q_cmd.status;
            end
        end
    end

endmodule

>>> hw/rtl/pcx_rle_decoder.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder
// Streaming decoder for 8-bit single-plane PCX images.
// ----------------------------------------------------------------------------
// Bytes of a PCX file enter on the input queue port (push/full), header
// first, with i_last_byte set on the final byte. The front end checks the
// 128-byte header, keeps the remaining pixel count and queues one command
// per byte that yields results. The back end expands commands into beats on
// the result queue port (empty/pop): one beat per pixel, and on the last
// byte a status beat (ok, bad header, data ended early) with o_last set.
// A byte is taken every cycle while the command queue has room. A literal
// pixel is written to the command queue and then to the back end's output
// register. The back end makes one beat per cycle while its output is
// free or popped, so n pixels of a run give n beats; the front end stalls
// once QUEUE_DEPTH commands wait. While pop is low the result beat holds
// and the queue fills, then full rises. Reset empties both sides and starts
// a new file; an accepted last byte also restarts the parser.
// ----------------------------------------------------------------------------
module pcx_rle_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_file_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_kind,
    output logic [7:0] o_pixel,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic              q_full, q_empty, q_push, q_pop;
    pcx_rle_pkg::t_cmd q_wdata, q_rdata;

    assign full = q_full;

    pcx_rle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (push),
        .i_file_byte (i_file_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_wdata)
    );

    pcx_rle_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    pcx_rle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_kind    (o_kind),
        .o_pixel   (o_pixel),
        .o_status  (o_status),
        .o_last    (o_last)
    );

endmodule

>>> hw/rtl/pcx_rle_decoder_chk.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder port checker
// Watches the decoder's ports and flags illegal result beats.
// ----------------------------------------------------------------------------
`include "pcx_rle_decoder_assert.svh"

module pcx_rle_decoder_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_kind,
    input logic [7:0] o_pixel,
    input logic [1:0] o_status,
    input logic       o_last
);

    `PCX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_pixel) && $stable(o_kind))
    `PCX_ASSERT_SAME(a_status_last, i_clk, i_rst_n, !empty && o_kind, o_last)
    `PCX_ASSERT_SAME(a_pixel_clean, i_clk, i_rst_n, !empty && !o_kind, o_status == 2'd0)
    `PCX_ASSERT_SAME(a_status_code, i_clk, i_rst_n, !empty && o_kind, o_status != 2'd3 && o_pixel == 8'd0)

endmodule

bind pcx_rle_decoder pcx_rle_decoder_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_kind   (o_kind),
    .o_pixel  (o_pixel),
    .o_status (o_status),
    .o_last   (o_last)
);
